[hdl/rsts_pkg.sv]
// ----------------------------------------------------------------------------
// rsts_pkg
// Shared types, operation and result codes for the sound trigger scheduler.
// ----------------------------------------------------------------------------
package rsts_pkg;

  localparam int unsigned NUM_SLOTS_DEF  = 16;
  localparam int unsigned TIMER_BITS_DEF = 16;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_STOP    = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_PLAY  = 2'd1;
  localparam logic [1:0] KIND_HELD  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // Slot id reported when no slot is given or acting.
  localparam logic [4:0] SLOT_NONE = 5'h1f;

  localparam logic [1:0] MODE_ONCE     = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_BEGIN    = 2'd2;
  localparam logic [1:0] MODE_MEASURE  = 2'd3;

  // Classified command handed from the front end to the slot engine.
  typedef struct packed {
    logic [1:0]  op;
    logic        play_now;
    logic        unknown;
    logic [15:0] sound;
    logic [15:0] delay;
    logic [15:0] interval;
    logic [13:0] count;
    logic [15:0] target;
    logic [31:0] mask;
    logic [4:0]  handle;
  } cmd_t;

endpackage

[hdl/rsts_front.sv]
// ----------------------------------------------------------------------------
// rsts_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rsts_front
  import rsts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [15:0] sound_id,
  input  logic [15:0] start_delay,
  input  logic [15:0] repeat_interval,
  input  logic [13:0] trigger_total,
  input  logic [15:0] target_slot,
  input  logic [31:0] busy_mask,
  input  logic [4:0]  free_handle,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_take
);

  cmd_t       q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r;
  logic       wr_r;
  cmd_t       c;
  logic [15:0] ival;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    ival = (trigger_total == 14'd1) ? 16'd0 : repeat_interval;
    c = '0;
    c.op       = op;
    c.unknown  = (op != OP_START) && (op != OP_STOP) && (op != OP_TICK);
    c.play_now = ($signed(start_delay) <= 16'sd0) && (ival == 16'd0);
    c.sound    = sound_id;
    c.delay    = start_delay;
    c.interval = ival;
    c.count    = trigger_total;
    c.target   = target_slot;
    c.mask     = busy_mask;
    c.handle   = free_handle;
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (do_push) wr_r <= !wr_r;
      if (do_pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_r] <= c;
  end

endmodule

[hdl/rsts_engine.sv]
// ----------------------------------------------------------------------------
// rsts_engine
// Slot engine: executes one command at a time, walking slots one per cycle
// on a tick while the output is free; result beats leave a single output register.
// ----------------------------------------------------------------------------
module rsts_engine
  import rsts_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_take,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [4:0]  slot_id,
  output logic [15:0] sound_out,
  output logic [4:0]  handle_out,
  output logic        last
);

  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned TB = TIMER_BITS;
  localparam logic [TB-1:0] TMAX = {1'b0, {(TB-1){1'b1}}};

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PLAY  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  logic [NUM_SLOTS-1:0] busy_r;
  logic [1:0]    mode_r   [NUM_SLOTS];
  logic [TB-1:0] timer_r  [NUM_SLOTS];
  logic [TB-1:0] period_r [NUM_SLOTS];
  logic [13:0]   rem_r    [NUM_SLOTS];
  logic [15:0]   snd_r    [NUM_SLOTS];
  logic [4:0]    hdl_r    [NUM_SLOTS];

  logic [1:0]    st_r;
  logic [SW-1:0] idx_r;
  cmd_t          cur_r;

  logic          ov_r;
  logic [1:0]    okind_r;
  logic [4:0]    oslot_r;
  logic [15:0]   osnd_r;
  logic [4:0]    ohdl_r;
  logic          olast_r;

  logic          out_free;
  logic          got_ok;
  logic [SW-1:0] got;
  logic          tgt_ok;
  logic [SW-1:0] tgt;

  assign out_free   = !ov_r || pop;
  assign empty      = !ov_r;
  assign kind       = okind_r;
  assign slot_id    = oslot_r;
  assign sound_out  = osnd_r;
  assign handle_out = ohdl_r;
  assign last       = olast_r;
  assign cmd_take   = (st_r == ST_IDLE) && out_free;

  // Lowest free slot.
  always_comb begin
    got_ok = 1'b0;
    got    = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        got_ok = 1'b1;
        got    = SW'(i);
      end
    end
  end

  always_comb begin
    tgt    = cmd.target[SW-1:0];
    tgt_ok = !cmd.target[15] && (cmd.target < 16'(NUM_SLOTS)) && busy_r[tgt];
  end

  // Current slot of the walk.
  logic [TB-1:0] t;
  logic          t_exp;
  logic [TB-1:0] pinc;
  logic [13:0]   rem;
  logic          walk_emit;
  logic          held_emit;
  always_comb begin
    t     = timer_r[idx_r];
    t_exp = $signed(t) <= $signed(TB'(1));
    pinc  = ($signed(period_r[idx_r]) < $signed(TMAX)) ? period_r[idx_r] + TB'(1)
                                                       : period_r[idx_r];
    rem   = rem_r[idx_r];
    held_emit = (mode_r[idx_r] == MODE_BEGIN) && t_exp;
    // A measuring slot plays once its handle has gone quiet; the others emit on expiry.
    if (mode_r[idx_r] == MODE_MEASURE) walk_emit = busy_r[idx_r] && !cur_r.mask[hdl_r[idx_r]];
    else walk_emit = busy_r[idx_r] && t_exp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      busy_r <= '0;
      ov_r   <= 1'b0;
      idx_r  <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) mode_r[i] <= MODE_ONCE;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (cmd_valid && out_free) begin
            cur_r  <= cmd;
            ov_r   <= (cmd.op != OP_TICK);
            ohdl_r <= '0;
            if (cmd.unknown) begin
              okind_r <= KIND_DONE;
              oslot_r <= SLOT_NONE;
              osnd_r  <= '0;
              olast_r <= 1'b1;
            end else if (cmd.op == OP_STOP) begin
              okind_r <= KIND_DONE;
              oslot_r <= tgt_ok ? 5'(tgt) : SLOT_NONE;
              osnd_r  <= '0;
              olast_r <= 1'b1;
              if (tgt_ok) busy_r[tgt] <= 1'b0;
            end else if (cmd.op == OP_TICK) begin
              idx_r <= '0;
              st_r  <= ST_WALK;
            end else if (cmd.play_now) begin
              okind_r <= KIND_PLAY;
              oslot_r <= SLOT_NONE;
              osnd_r  <= cmd.sound;
              olast_r <= 1'b0;
              st_r    <= ST_PLAY;
            end else begin
              okind_r <= KIND_REPLY;
              oslot_r <= got_ok ? 5'(got) : SLOT_NONE;
              osnd_r  <= '0;
              olast_r <= 1'b1;
              if (got_ok) begin
                busy_r[got] <= 1'b1;
                timer_r[got] <= TB'($signed(cmd.delay));
                snd_r[got] <= cmd.sound;
                rem_r[got] <= cmd.count;
                hdl_r[got] <= '0;
                if (cmd.interval == 16'd0) begin
                  mode_r[got] <= MODE_ONCE;
                  period_r[got] <= '0;
                end else if (cmd.interval[15]) begin
                  mode_r[got] <= MODE_BEGIN;
                  period_r[got] <= '0;
                end else begin
                  mode_r[got] <= MODE_PERIODIC;
                  period_r[got] <= TB'(cmd.interval);
                end
              end
            end
          end else if (out_free) begin
            ov_r <= 1'b0;
          end
        end
        ST_PLAY: begin
          if (out_free) begin
            ov_r    <= 1'b1;
            okind_r <= KIND_REPLY;
            oslot_r <= SLOT_NONE;
            osnd_r  <= '0;
            olast_r <= 1'b1;
            st_r    <= ST_IDLE;
          end
        end
        ST_WALK: begin
          if (out_free) begin
            ov_r    <= walk_emit;
            osnd_r  <= snd_r[idx_r];
            oslot_r <= 5'(idx_r);
            ohdl_r  <= held_emit ? cur_r.handle : 5'd0;
            olast_r <= 1'b0;
            okind_r <= held_emit ? KIND_HELD : KIND_PLAY;
            if (busy_r[idx_r]) begin
              case (mode_r[idx_r])
                MODE_ONCE: begin
                  if (t_exp) begin
                    busy_r[idx_r] <= 1'b0;
                  end else begin
                    timer_r[idx_r] <= t - TB'(1);
                  end
                end
                MODE_PERIODIC: begin
                  if (t_exp) begin
                    timer_r[idx_r] <= period_r[idx_r];
                    if (rem != 14'd0) begin
                      rem_r[idx_r] <= rem - 14'd1;
                      if (rem == 14'd1) busy_r[idx_r] <= 1'b0;
                    end
                  end else begin
                    timer_r[idx_r] <= t - TB'(1);
                  end
                end
                MODE_BEGIN: begin
                  if (t_exp) begin
                    hdl_r[idx_r] <= cur_r.handle;
                    period_r[idx_r] <= '0;
                    mode_r[idx_r] <= MODE_MEASURE;
                    if (rem != 14'd0) rem_r[idx_r] <= rem - 14'd1;
                  end else begin
                    timer_r[idx_r] <= t - TB'(1);
                  end
                end
                default: begin
                  period_r[idx_r] <= pinc;
                  if (!cur_r.mask[hdl_r[idx_r]]) begin
                    timer_r[idx_r] <= pinc;
                    mode_r[idx_r] <= MODE_PERIODIC;
                    if (rem != 14'd0) begin
                      rem_r[idx_r] <= rem - 14'd1;
                      if (rem == 14'd1) busy_r[idx_r] <= 1'b0;
                    end
                  end
                end
              endcase
            end
            if (idx_r == SW'(NUM_SLOTS - 1)) st_r <= ST_FINAL;
            else idx_r <= idx_r + SW'(1);
          end
        end
        default: begin
          if (out_free) begin
            ov_r    <= 1'b1;
            okind_r <= KIND_DONE;
            oslot_r <= SLOT_NONE;
            osnd_r  <= '0;
            ohdl_r  <= '0;
            olast_r <= 1'b1;
            st_r    <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

[hdl/repeating_sound_trigger_scheduler.sv]
// ----------------------------------------------------------------------------
// repeating_sound_trigger_scheduler
// Sixteen-slot scheduler for delayed, periodic and measured sound triggers.
// ----------------------------------------------------------------------------
// Input beats are pushed while full is low; each carries op (start, stop or
// frame tick) and its operands. A two-entry queue separates the front end
// from the slot engine. Result beats appear while empty is low and leave on
// pop; last marks the final beat of one input item.
// Start and stop are handled from the idle state; an immediate play passes
// through the play state before its reply. A tick walks every slot, one per
// cycle while the output is free, then emits its done beat from the final state.
// A start or stop reply passes the input queue and the output register; the
// first beat of a tick is registered only once the walk has begun.
// Reset frees all slots and empties the input queue and the output register.
// When the receiver stalls, the engine holds in place behind its single
// output register and the input queue fills, then full rises.
// ----------------------------------------------------------------------------
module repeating_sound_trigger_scheduler
  import rsts_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_sound_id,
  input  logic [15:0] in_start_delay,
  input  logic [15:0] in_repeat_interval,
  input  logic [13:0] in_trigger_total,
  input  logic [15:0] in_target_slot,
  input  logic [31:0] in_busy_mask,
  input  logic [4:0]  in_free_handle,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [4:0]  out_slot_id,
  output logic [15:0] out_sound_out,
  output logic [4:0]  out_handle_out,
  output logic        out_last
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  rsts_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .op(in_op), .sound_id(in_sound_id), .start_delay(in_start_delay),
    .repeat_interval(in_repeat_interval), .trigger_total(in_trigger_total),
    .target_slot(in_target_slot), .busy_mask(in_busy_mask),
    .free_handle(in_free_handle),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  rsts_engine #(.NUM_SLOTS(NUM_SLOTS), .TIMER_BITS(TIMER_BITS)) u_engine (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .empty(empty), .pop(pop),
    .kind(out_kind), .slot_id(out_slot_id), .sound_out(out_sound_out),
    .handle_out(out_handle_out), .last(out_last)
  );

endmodule

[tb/tb_repeating_sound_trigger_scheduler.sv]
// ----------------------------------------------------------------------------
// tb_repeating_sound_trigger_scheduler
// Self-checking bench for the sixteen-slot sound trigger scheduler.
// ----------------------------------------------------------------------------
// A directed table covers starts, stops, ticks and the unknown op. Random
// sequences of starts, stops, ticks and unknown ops then follow. Every accepted
// input beat is run through a behavioral slot model, and each result beat is
// compared with the oldest predicted beat.
// ----------------------------------------------------------------------------
module tb_repeating_sound_trigger_scheduler;
  import rsts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] sound;
    logic [15:0] delay;
    logic [15:0] interval;
    logic [13:0] count;
    logic [15:0] target;
    logic [31:0] mask;
    logic [4:0]  handle;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  slot;
    logic [15:0] sound;
    logic [4:0]  handle;
    logic        last;
  } beat_t;

  // A directed row; has_exp marks a row whose single reply is typed in.
  typedef struct packed {
    req_t  req;
    logic  has_exp;
    beat_t exp;
  } row_t;

  logic        clk, rst_n, push, full, empty, pop;
  logic [1:0]  in_op;
  logic [15:0] in_sound_id, in_start_delay, in_repeat_interval, in_target_slot;
  logic [13:0] in_trigger_total;
  logic [31:0] in_busy_mask;
  logic [4:0]  in_free_handle;
  logic [1:0]  out_kind;
  logic [4:0]  out_slot_id, out_handle_out;
  logic [15:0] out_sound_out;
  logic        out_last;

  repeating_sound_trigger_scheduler dut (.*);

  // Model state.
  logic        m_busy   [NSLOT];
  logic [1:0]  m_mode   [NSLOT];
  logic [15:0] m_timer  [NSLOT];
  logic [15:0] m_period [NSLOT];
  logic [13:0] m_remain [NSLOT];
  logic [15:0] m_sound  [NSLOT];
  logic [4:0]  m_handle [NSLOT];

  beat_t pending_beats[$];
  int    errors;
  int    send_idle, recv_idle;

  function automatic beat_t mk(logic [1:0] k, int s, logic [15:0] snd, logic [4:0] h);
    beat_t b;
    b.kind = k; b.slot = 5'(s); b.sound = snd; b.handle = h; b.last = 1'b0;
    return b;
  endfunction

  function automatic void count_play(int s);
    if (m_remain[s] != 14'd0) begin
      m_remain[s] = m_remain[s] - 14'd1;
      if (m_remain[s] == 14'd0) m_busy[s] = 1'b0;
    end
  endfunction

  task automatic schedule_item(req_t r);
    beat_t q[$];
    logic signed [15:0] iv, t, p;
    int got;
    iv = r.interval;
    case (r.op)
      OP_START: begin
        got = -1;
        if (r.count == 14'd1) iv = '0;
        if ($signed(r.delay) <= 0 && iv == 0) begin
          q.push_back(mk(KIND_PLAY, -1, r.sound, '0));
        end else begin
          for (int s = 0; s < NSLOT; s++)
            if (!m_busy[s] && got < 0) got = s;
          if (got >= 0) begin
            m_busy[got] = 1'b1;
            m_timer[got] = r.delay;
            m_sound[got] = r.sound;
            m_remain[got] = r.count;
            m_handle[got] = '0;
            m_period[got] = '0;
            if (iv == 0) m_mode[got] = MODE_ONCE;
            else if (iv < 0) m_mode[got] = MODE_BEGIN;
            else begin
              m_mode[got] = MODE_PERIODIC;
              m_period[got] = iv;
            end
          end
        end
        q.push_back(mk(KIND_REPLY, got, '0, '0));
      end
      OP_STOP: begin
        got = -1;
        if ($signed(r.target) >= 0 && $signed(r.target) < NSLOT) begin
          if (m_busy[r.target[3:0]]) begin
            m_busy[r.target[3:0]] = 1'b0;
            got = int'(r.target[3:0]);
          end
        end
        q.push_back(mk(KIND_DONE, got, '0, '0));
      end
      OP_TICK: begin
        for (int s = 0; s < NSLOT; s++) begin
          if (m_busy[s]) begin
            t = m_timer[s];
            case (m_mode[s])
              MODE_ONCE: begin
                if (t <= 1) begin
                  q.push_back(mk(KIND_PLAY, s, m_sound[s], '0));
                  m_busy[s] = 1'b0;
                end else m_timer[s] = t - 16'sd1;
              end
              MODE_PERIODIC: begin
                if (t <= 1) begin
                  q.push_back(mk(KIND_PLAY, s, m_sound[s], '0));
                  m_timer[s] = m_period[s];
                  count_play(s);
                end else m_timer[s] = t - 16'sd1;
              end
              MODE_BEGIN: begin
                if (t <= 1) begin
                  m_handle[s] = r.handle;
                  q.push_back(mk(KIND_HELD, s, m_sound[s], r.handle));
                  m_period[s] = '0;
                  m_mode[s] = MODE_MEASURE;
                  if (m_remain[s] != 14'd0) m_remain[s] = m_remain[s] - 14'd1;
                end else m_timer[s] = t - 16'sd1;
              end
              default: begin
                p = m_period[s];
                if (p < 16'sh7fff) p = p + 16'sd1;
                m_period[s] = p;
                if (!r.mask[m_handle[s]]) begin
                  q.push_back(mk(KIND_PLAY, s, m_sound[s], '0));
                  m_timer[s] = m_period[s];
                  m_mode[s] = MODE_PERIODIC;
                  count_play(s);
                end
              end
            endcase
          end
        end
        q.push_back(mk(KIND_DONE, -1, '0, '0));
      end
      default: q.push_back(mk(KIND_DONE, -1, '0, '0));
    endcase
    q[q.size()-1].last = 1'b1;
    foreach (q[i]) pending_beats.push_back(q[i]);
  endtask

  // Directed table and its row builders.
  row_t table_rows[$];

  function automatic req_t rq(logic [1:0] op, logic [15:0] snd, logic [15:0] d,
                              logic [15:0] iv, logic [13:0] c, logic [15:0] tg,
                              logic [31:0] m, logic [4:0] h);
    req_t r;
    r.op = op; r.sound = snd; r.delay = d; r.interval = iv; r.count = c;
    r.target = tg; r.mask = m; r.handle = h;
    return r;
  endfunction

  function automatic void add_row(req_t r);
    row_t w;
    w.req = r; w.has_exp = 1'b0; w.exp = '0;
    table_rows.push_back(w);
  endfunction

  function automatic void add_row_exp(req_t r, beat_t e);
    row_t w;
    w.req = r; w.has_exp = 1'b1; w.exp = e; w.exp.last = 1'b1;
    table_rows.push_back(w);
  endfunction

  function automatic req_t rand_req(bit tick_heavy);
    req_t r;
    int sel;
    r.sound = 16'($urandom);
    r.target = 16'($urandom);
    r.mask = $urandom;
    r.handle = 5'($urandom);
    r.count = ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'($urandom_range(0, 4));
    r.delay = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
              16'($signed($urandom_range(0, 6)) - 1);
    case ($urandom_range(0, 3))
      0: r.interval = 0;
      1: r.interval = 16'(-$signed($urandom_range(1, 3)));
      2: r.interval = 16'($urandom_range(1, 5));
      default: r.interval = 16'($urandom);
    endcase
    if ($urandom_range(0, 3) != 0) r.target = 16'($urandom_range(0, 17));
    // Sparse masks let measured slots finish their held play.
    if ($urandom_range(0, 1) != 0) r.mask = $urandom & $urandom & $urandom;
    sel = $urandom_range(0, 99);
    if (sel < (tick_heavy ? 55 : 30)) r.op = OP_TICK;
    else if (sel < 85) r.op = OP_START;
    else if (sel < 97) r.op = OP_STOP;
    else r.op = OP_UNKNOWN;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  // Checker and receiver.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        beat_t got, want;
        got = {out_kind, out_slot_id, out_sound_out, out_handle_out, out_last};
        if (pending_beats.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat %h", got);
        end else begin
          want = pending_beats.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp kind %0d slot %0d snd %h h %0d last %b, got %0d %0d %h %0d %b",
                       want.kind, $signed(want.slot), want.sound, want.handle, want.last,
                       got.kind, $signed(got.slot), got.sound, got.handle, got.last);
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Push stays high from one item to the next when the sender does not idle;
  // drain lowers it.
  task automatic send(req_t r);
    do begin
      while ($urandom_range(0, 99) < send_idle) begin
        push <= 1'b0;
        @(posedge clk);
      end
      push <= 1'b1;
      {in_op, in_sound_id, in_start_delay, in_repeat_interval, in_trigger_total,
       in_target_slot, in_busy_mask, in_free_handle} <= r;
      @(posedge clk);
    end while (full);
    schedule_item(r);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    push <= 1'b0;
    while (pending_beats.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  initial begin
    beat_t e;
    errors = 0; send_idle = 0; recv_idle = 0;
    rst_n = 1'b0; push = 1'b0; pop = 1'b0;
    {in_op, in_sound_id, in_start_delay, in_repeat_interval, in_trigger_total,
     in_target_slot, in_busy_mask, in_free_handle} = '0;
    foreach (m_busy[s]) begin
      m_busy[s] = 0; m_mode[s] = 0; m_timer[s] = 0; m_period[s] = 0;
      m_remain[s] = 0; m_sound[s] = 0; m_handle[s] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows.
    add_row_exp(rq(OP_TICK, 0, 0, 0, 0, 0, 0, 0), mk(KIND_DONE, -1, 0, 0));
    add_row_exp(rq(OP_STOP, 0, 0, 0, 0, 0, 0, 0), mk(KIND_DONE, -1, 0, 0));
    add_row_exp(rq(OP_STOP, 0, 0, 0, 0, 16'h8000, 0, 0), mk(KIND_DONE, -1, 0, 0));
    add_row_exp(rq(OP_STOP, 0, 0, 0, 0, 16'h7fff, 0, 0), mk(KIND_DONE, -1, 0, 0));
    add_row_exp(rq(OP_UNKNOWN, 16'hffff, 16'hffff, 16'hffff, 14'h3fff, 16'hffff,
                   32'hffffffff, 5'h1f), mk(KIND_DONE, -1, 0, 0));
    add_row(rq(OP_START, 16'hffff, 16'h8000, 16'h0000, 0, 0, 0, 0));
    add_row(rq(OP_START, 16'h1234, 16'h0000, 16'h7fff, 1, 0, 0, 0));
    add_row(rq(OP_START, 16'h0001, 16'h0002, 16'h0000, 0, 0, 0, 0));
    add_row(rq(OP_START, 16'h0002, 16'h0001, 16'h0003, 3, 0, 0, 0));
    add_row(rq(OP_START, 16'h0003, 16'h0001, 16'hffff, 2, 0, 0, 0));
    add_row(rq(OP_START, 16'h0004, 16'h7fff, 16'h8000, 14'h3fff, 0, 0, 0));
    add_row(rq(OP_START, 16'h0005, 16'h0000, 16'h0002, 0, 0, 0, 0));
    add_row(rq(OP_TICK, 0, 0, 0, 0, 0, 32'hffffffff, 5'h1f));
    add_row(rq(OP_TICK, 0, 0, 0, 0, 0, 32'h80000000, 5'h00));
    add_row(rq(OP_TICK, 0, 0, 0, 0, 0, 32'h00000000, 5'h0a));
    add_row(rq(OP_TICK, 0, 0, 0, 0, 0, 32'h00000000, 5'h0a));
    add_row(rq(OP_STOP, 0, 0, 0, 0, 16'd3, 0, 0));
    add_row(rq(OP_STOP, 0, 0, 0, 0, 16'd15, 0, 0));
    for (int i = 0; i < 16; i++) add_row(rq(OP_START, 16'(i), 5, 1, 0, 0, 0, 0));
    add_row(rq(OP_TICK, 0, 0, 0, 0, 0, 0, 0));

    foreach (table_rows[i]) begin
      if (table_rows[i].has_exp) begin
        drain();
        e = table_rows[i].exp;
        send(table_rows[i].req);
        if (pending_beats.size() != 1 || pending_beats[0] !== e) begin
          errors++;
          if (errors <= 10)
            $display("directed row %0d: exp %h, model %h (%0d beats)", i, e,
                     (pending_beats.size() != 0) ? pending_beats[0] : beat_t'('0),
                     pending_beats.size());
        end
      end else begin
        send(table_rows[i].req);
      end
    end
    // Hold off until everything is out, then clear every slot.
    drain();
    for (int s = 0; s < NSLOT; s++) send(rq(OP_STOP, 0, 0, 0, 0, 16'(s), 0, 0));

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 31 : (ph == 1) ? 87 : 0;
      recv_idle = (ph == 0) ? 87 : (ph == 1) ? 31 : 0;
      for (int i = 0; i < 145; i++) begin
        send(rand_req(i % 40 >= 20));
        if (i == 80 && ph == 2) drain();
      end
    end
    drain();

    if (errors == 0 && pending_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/rsts_pkg.sv
hdl/rsts_front.sv
hdl/rsts_engine.sv
hdl/repeating_sound_trigger_scheduler.sv
tb/tb_repeating_sound_trigger_scheduler.sv
